>>> rtl/faar_pkg.sv
// Shared types and constants for the flat address aperture resolve block.
// Used by the channel interfaces and by every module under rtl/.
package faar_pkg;

  // Field widths.
  localparam int LANE_W      = 6;
  localparam int ADDR_W      = 64;
  localparam int WORD_W      = 32;
  localparam int LDS_BYTES_W = 17;
  localparam int PROD_W      = LANE_W + WORD_W;
  localparam int CFG_IDX_W   = 4;

  // Lanes per wavefront; lane numbers at or above this count are inactive.
  localparam int WAVE_LANES = 64;

  // Reset value of the local share size register.
  localparam logic [LDS_BYTES_W-1:0] LDS_BYTES_RESET = 17'h10000;

  // Non-canonical hole: address bits HOLE_HI..HOLE_LO must be all zero or all one.
  localparam int HOLE_HI = 63;
  localparam int HOLE_LO = 47;
  localparam logic [HOLE_HI-HOLE_LO:0] HOLE_ALL_ONES = 17'h1FFFF;

  // Depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LDS_BASE       = 4'd0,
    CFG_LDS_LIMIT      = 4'd1,
    CFG_SCRATCH_BASE   = 4'd2,
    CFG_SCRATCH_LIMIT  = 4'd3,
    CFG_GPUVM_BASE     = 4'd4,
    CFG_GPUVM_LIMIT    = 4'd5,
    CFG_PRIV_ADJUST    = 4'd6,
    CFG_LDS_BYTES      = 4'd7
  } cfg_idx_t;

  // Segment codes as they appear on the result channel.
  typedef enum logic [1:0] {
    SEG_GLOBAL  = 2'd0,
    SEG_LDS     = 2'd1,
    SEG_PRIVATE = 2'd2,
    SEG_NONE    = 2'd3
  } seg_t;

  // Address class: the segments plus the two error classes.
  typedef enum logic [2:0] {
    CLS_GLOBAL  = 3'd0,
    CLS_LDS     = 3'd1,
    CLS_PRIVATE = 3'd2,
    CLS_NONE    = 3'd3,
    CLS_GPUVM   = 3'd4,
    CLS_HOLE    = 3'd5
  } cls_t;

  // Fault codes.
  typedef enum logic [2:0] {
    FLT_OK        = 3'd0,
    FLT_GPUVM     = 3'd1,
    FLT_HOLE      = 3'd2,
    FLT_STRADDLE  = 3'd3,
    FLT_LDS_RANGE = 3'd4,
    FLT_NO_ACTIVE = 3'd5
  } fault_t;

  // Configuration register file contents.
  typedef struct packed {
    logic [ADDR_W-1:0]      lds_base;
    logic [ADDR_W-1:0]      lds_limit;
    logic [ADDR_W-1:0]      scratch_base;
    logic [ADDR_W-1:0]      scratch_limit;
    logic [ADDR_W-1:0]      gpuvm_base;
    logic [ADDR_W-1:0]      gpuvm_limit;
    logic [ADDR_W-1:0]      priv_adjust;
    logic [LDS_BYTES_W-1:0] lds_bytes;
  } cfg_t;

  // One classified lane as it waits in the queue for the back part.
  typedef struct packed {
    logic              active;
    cls_t              cls;
    logic              last;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] lds_addr;
    logic              lds_oor;
    logic [ADDR_W-1:0] priv_addr;
  } q_item_t;

endpackage

>>> rtl/faar_if.sv
// Channel interfaces: lane input, result output and configuration write.
// Depends on faar_pkg for field widths.
interface faar_lane_if;
  import faar_pkg::*;
  logic              valid;
  logic              ready;
  logic [LANE_W-1:0] lane_number;
  logic              lane_active;
  logic [ADDR_W-1:0] flat_address;
  logic              last_lane;
  logic [WORD_W-1:0] wave_private_offset;
  logic [WORD_W-1:0] wave_lane_stride;

  modport source (output valid, lane_number, lane_active, flat_address, last_lane,
                  wave_private_offset, wave_lane_stride, input ready);
  modport sink (input valid, lane_number, lane_active, flat_address, last_lane,
                wave_private_offset, wave_lane_stride, output ready);
endinterface

interface faar_res_if;
  import faar_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        segment;
  logic [ADDR_W-1:0] segment_address;
  logic [2:0]        fault;
  logic              lane_done;

  modport source (output valid, segment, segment_address, fault, lane_done, input ready);
  modport sink (input valid, segment, segment_address, fault, lane_done, output ready);
endinterface

interface faar_cfg_if;
  import faar_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [ADDR_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/flat_address_aperture_resolve_core.sv
// Top level of the flat address aperture resolve block: configuration
// registers, front part, queue and back part.
// Depends on faar_pkg, faar_if, faar_front, faar_queue and faar_back.
//
//   channel  direction  handshake      content
//   lane_in  in         valid/ready    one lane address with active and last marks
//   res_out  out        valid/ready    segment, translated address, fault, lane done
//   cfg      in         valid/ready    register index and 64-bit write data
//
// One lane is taken every cycle while the front stage can move into the queue.
// The pace is set by the front register (aperture compares, local share offset and
// lane product), whose private address sum completes on the way into a two-entry queue.
// Reset clears the chosen segment, the queue and the result valid flag and
// loads the register defaults. A stalled result stalls the back part alone
// until the queue fills; the front then holds its stage and lowers ready.
module flat_address_aperture_resolve_core (
  input  logic clk,
  input  logic rst,
  faar_lane_if.sink   lane_in,
  faar_res_if.source  res_out,
  faar_cfg_if.sink    cfg
);
  import faar_pkg::*;

  cfg_t    cfg_regs;
  logic    q_can_push;
  logic    q_push;
  q_item_t q_data;
  logic    q_pop;
  logic    q_not_empty;
  q_item_t q_head;

  // Configuration writes are always taken.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.lds_base      <= '0;
      cfg_regs.lds_limit     <= '0;
      cfg_regs.scratch_base  <= '0;
      cfg_regs.scratch_limit <= '0;
      cfg_regs.gpuvm_base    <= '0;
      cfg_regs.gpuvm_limit   <= '0;
      cfg_regs.priv_adjust   <= '0;
      cfg_regs.lds_bytes     <= LDS_BYTES_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_LDS_BASE:      cfg_regs.lds_base      <= cfg.data;
        CFG_LDS_LIMIT:     cfg_regs.lds_limit     <= cfg.data;
        CFG_SCRATCH_BASE:  cfg_regs.scratch_base  <= cfg.data;
        CFG_SCRATCH_LIMIT: cfg_regs.scratch_limit <= cfg.data;
        CFG_GPUVM_BASE:    cfg_regs.gpuvm_base    <= cfg.data;
        CFG_GPUVM_LIMIT:   cfg_regs.gpuvm_limit   <= cfg.data;
        CFG_PRIV_ADJUST:   cfg_regs.priv_adjust   <= cfg.data;
        CFG_LDS_BYTES:     cfg_regs.lds_bytes     <= cfg.data[LDS_BYTES_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Classification and precomputed translations.
  faar_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_regs   (cfg_regs),
    .lane_in    (lane_in),
    .q_can_push (q_can_push),
    .q_push     (q_push),
    .q_data     (q_data)
  );

  // Decoupling queue.
  faar_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .can_push  (q_can_push),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // Segment tracking and result register.
  faar_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .res_out     (res_out)
  );

endmodule

>>> rtl/faar_front.sv
// Front part: accepts lanes, classifies the address against the apertures and
// precomputes both translations. Depends on faar_pkg and faar_if.
module faar_front (
  input  logic              clk,
  input  logic              rst,
  input  faar_pkg::cfg_t    cfg_regs,
  faar_lane_if.sink         lane_in,
  input  logic              q_can_push,
  output logic              q_push,
  output faar_pkg::q_item_t q_data
);
  import faar_pkg::*;

  // First stage registers.
  logic                 s1_valid;
  logic                 s1_active;
  cls_t                 s1_cls;
  logic                 s1_last;
  logic [ADDR_W-1:0]    s1_addr;
  logic [ADDR_W-1:0]    s1_lds_addr;
  logic [PROD_W-1:0]    s1_prod;
  logic [ADDR_W-1:0]    s1_off_adj;

  logic                 take;
  logic                 active_eff;
  cls_t                 cls_now;
  logic [HOLE_HI-HOLE_LO:0] top_bits;
  logic                 in_lds;
  logic                 in_scratch;
  logic                 in_gpuvm;
  logic [ADDR_W-1:0]    lds_addr_cmp;

  // A lane enters when the stage is empty or its content moves into the queue.
  assign lane_in.ready = !s1_valid || q_can_push;
  assign take          = lane_in.valid && lane_in.ready;

  // Aperture and hole classification, tested in priority order.
  always_comb begin
    top_bits   = lane_in.flat_address[HOLE_HI:HOLE_LO];
    in_lds     = (cfg_regs.lds_base <= lane_in.flat_address) &&
                 (lane_in.flat_address <= cfg_regs.lds_limit);
    in_scratch = (cfg_regs.scratch_base <= lane_in.flat_address) &&
                 (lane_in.flat_address <= cfg_regs.scratch_limit);
    in_gpuvm   = (cfg_regs.gpuvm_base <= lane_in.flat_address) &&
                 (lane_in.flat_address <= cfg_regs.gpuvm_limit);
    if (in_lds) begin
      cls_now = CLS_LDS;
    end else if (in_scratch) begin
      cls_now = CLS_PRIVATE;
    end else if (in_gpuvm) begin
      cls_now = CLS_GPUVM;
    end else if (top_bits != '0 && top_bits != HOLE_ALL_ONES) begin
      cls_now = CLS_HOLE;
    end else begin
      cls_now = CLS_GLOBAL;
    end
    active_eff = lane_in.lane_active && (int'(lane_in.lane_number) < WAVE_LANES);
  end

  // Stage one valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (lane_in.ready) begin
      s1_valid <= take;
    end
  end

  // Stage one payload: class, local share offset, lane product, offset sum.
  always_ff @(posedge clk) begin
    if (take) begin
      s1_active   <= active_eff;
      s1_cls      <= cls_now;
      s1_last     <= lane_in.last_lane;
      s1_addr     <= lane_in.flat_address;
      s1_lds_addr <= lane_in.flat_address - cfg_regs.lds_base;
      s1_prod     <= PROD_W'(lane_in.lane_number) * PROD_W'(lane_in.wave_lane_stride);
      s1_off_adj  <= ADDR_W'(lane_in.wave_private_offset) + cfg_regs.priv_adjust;
    end
  end

  // Second step: finish the private sum and the local share range check.
  assign lds_addr_cmp = ADDR_W'(cfg_regs.lds_bytes);
  assign q_push       = s1_valid && q_can_push;

  always_comb begin
    q_data.active    = s1_active;
    q_data.cls       = s1_cls;
    q_data.last      = s1_last;
    q_data.addr      = s1_addr;
    q_data.lds_addr  = s1_lds_addr;
    q_data.lds_oor   = (s1_lds_addr >= lds_addr_cmp);
    q_data.priv_addr = s1_addr + ADDR_W'(s1_prod) + s1_off_adj;
  end

endmodule

>>> rtl/faar_queue.sv
// Short queue between the front and back parts.
// Depends on faar_pkg for the entry type and depth.
module faar_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  faar_pkg::q_item_t push_data,
  output logic              can_push,
  input  logic              pop,
  output logic              not_empty,
  output faar_pkg::q_item_t head
);
  import faar_pkg::*;

  q_item_t           entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign can_push  = (count != QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

>>> rtl/faar_back.sv
// Back part: tracks the segment chosen for the current access, applies the
// straddle rules, picks the translated address and holds the result register.
// Depends on faar_pkg and faar_if.
module faar_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_not_empty,
  input  faar_pkg::q_item_t q_head,
  output logic              q_pop,
  faar_res_if.source        res_out
);
  import faar_pkg::*;

  seg_t              chosen;
  seg_t              chosen_next;
  logic              out_valid;
  seg_t              seg_r;
  logic [ADDR_W-1:0] addr_r;
  fault_t            fault_r;
  logic              done_r;

  seg_t              seg_c;
  logic [ADDR_W-1:0] addr_c;
  fault_t            fault_c;

  // Take the head of the queue when the result register is free or draining.
  assign q_pop = q_not_empty && (!out_valid || res_out.ready);

  // Segment decision and translation for the head lane.
  always_comb begin
    seg_c       = SEG_NONE;
    addr_c      = q_head.addr;
    fault_c     = FLT_OK;
    chosen_next = chosen;
    if (q_head.active) begin
      if (chosen == SEG_NONE) begin
        if (q_head.cls == CLS_GPUVM) begin
          fault_c = FLT_GPUVM;
        end else if (q_head.cls == CLS_HOLE) begin
          fault_c = FLT_HOLE;
        end else begin
          chosen_next = seg_t'(q_head.cls[1:0]);
        end
      end else if (q_head.cls != cls_t'({1'b0, chosen})) begin
        fault_c = FLT_STRADDLE;
        seg_c   = chosen;
      end
      if (fault_c == FLT_OK) begin
        seg_c = chosen_next;
        case (chosen_next)
          SEG_LDS: begin
            addr_c = q_head.lds_addr;
            if (q_head.lds_oor) begin
              fault_c = FLT_LDS_RANGE;
            end
          end
          SEG_PRIVATE: begin
            addr_c = q_head.priv_addr;
          end
          default: begin
            addr_c = q_head.addr;
          end
        endcase
      end
    end else if (q_head.last && chosen == SEG_NONE) begin
      fault_c = FLT_NO_ACTIVE;
    end
    if (q_head.last) begin
      chosen_next = SEG_NONE;
    end
  end

  // Chosen segment and result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      chosen    <= SEG_NONE;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        chosen <= chosen_next;
      end
      if (q_pop) begin
        out_valid <= 1'b1;
      end else if (res_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      seg_r   <= seg_c;
      addr_r  <= addr_c;
      fault_r <= fault_c;
      done_r  <= q_head.last;
    end
  end

  assign res_out.valid           = out_valid;
  assign res_out.segment         = seg_r;
  assign res_out.segment_address = addr_r;
  assign res_out.fault           = fault_r;
  assign res_out.lane_done       = done_r;

endmodule
